[design/dvr_pkg.sv]
// Shared types, constants and helper functions for the dominated vertex reducer.
// Used by the channel interfaces, the adjacency RAM and the core.
package dvr_pkg;

   localparam int unsigned NodeCount = 64;
   localparam int unsigned NodeWidth = $clog2(NodeCount);

   typedef logic [NodeWidth-1:0] node_type;
   typedef logic [NodeCount-1:0] row_type;

   // function codes of an input item
   localparam logic FuncWrite  = 1'b0;
   localparam logic FuncReduce = 1'b1;

   // one access cycle of the adjacency RAM
   typedef struct packed {
      logic     rd_en;
      node_type rd_addr;
      logic     wr_en;
      node_type wr_addr;
      row_type  wr_data;
   } adj_req_type;

   // index of the lowest set bit, zero for an empty row
   function automatic node_type lowest_index(row_type x);
      node_type idx;
      idx = '0;
      for (int i = NodeCount - 1; i >= 0; i--) begin
         if (x[i]) begin
            idx = node_type'(i);
         end
      end
      return idx;
   endfunction

   function automatic row_type node_bit(node_type n);
      return row_type'(1) << n;
   endfunction

endpackage

[design/dvr_chan_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on dvr_pkg for node and row types.
interface dvr_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   dvr_pkg::node_type  node_index;
   dvr_pkg::row_type   row_bits;
   logic               in_lower_bound;

   modport source (output valid, func, node_index, row_bits, in_lower_bound, input ready);
   modport sink (input valid, func, node_index, row_bits, in_lower_bound, output ready);
endinterface

interface dvr_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   dvr_pkg::node_type  dominating_node;
   dvr_pkg::node_type  neighbour;
   logic               neighbour_in_lower_bound;
   logic               last;

   modport source (output valid, found, dominating_node, neighbour,
                   neighbour_in_lower_bound, last, input ready);
   modport sink (input valid, found, dominating_node, neighbour,
                 neighbour_in_lower_bound, last, output ready);
endinterface

[design/dominated_vertex_reducer_core.sv]
// Dominated vertex reducer top level: sequencer, lower-bound mask, response register.
// Depends on dvr_pkg, dvr_chan_if and dvr_adj_ram.
//
//  channel   dir  fields                                               handshake
//  req_chan  in   func, node_index, row_bits, in_lower_bound           valid/ready
//  rsp_chan  out  found, dominating_node, neighbour,                   valid/ready
//                 neighbour_in_lower_bound, last
//
// A write item writes its row as it is accepted. A reduce item reads the node's row, then
// intersects the neighbour rows one read per cycle, then decides; on a hit it emits one
// response per neighbour while it read-modify-writes each neighbour row, then clears the
// node; a miss, or a node of degree zero, gives a single response with found low.
// The single RAM read port sets both loops. Reset clears all rows at once through
// per-row valid bits; no clearing pass. A stalled response holds the emit loop.
module dominated_vertex_reducer_core (
   input logic          clock,
   input logic          reset,
   dvr_req_if.sink      req_chan,
   dvr_rsp_if.source    rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NBRS,
      S_SCAN,
      S_DECIDE,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   dvr_pkg::node_type      v_ff, v_in;
   dvr_pkg::node_type      u_ff, u_in;
   dvr_pkg::node_type      wr_addr_ff, wr_addr_in;
   dvr_pkg::row_type       nbrs_ff, nbrs_in;
   dvr_pkg::row_type       cand_ff, cand_in;
   dvr_pkg::row_type       rest_ff, rest_in;
   dvr_pkg::row_type       lb_ff, lb_in;
   logic                   pend_ff, pend_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   dvr_pkg::node_type      rsp_dom_ff, rsp_dom_in;
   dvr_pkg::node_type      rsp_nbr_ff, rsp_nbr_in;
   logic                   rsp_nlb_ff, rsp_nlb_in;
   logic                   rsp_last_ff, rsp_last_in;

   dvr_pkg::adj_req_type   adj_req;
   dvr_pkg::row_type       rd_data;
   dvr_pkg::row_type       vbit;
   dvr_pkg::row_type       req_bit;
   dvr_pkg::row_type       rest_next;
   dvr_pkg::node_type      rest_low;
   logic                   slot_free;
   logic                   req_fire;

   dvr_adj_ram u_adj_ram (
      .clock   (clock),
      .reset   (reset),
      .adj_req (adj_req),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign vbit           = dvr_pkg::node_bit(v_ff);
   assign req_bit        = dvr_pkg::node_bit(req_chan.node_index);
   assign rest_low       = dvr_pkg::lowest_index(rest_ff);
   assign rest_next      = rest_ff & (rest_ff - dvr_pkg::row_type'(1));

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      wr_addr_in   = wr_addr_ff;
      nbrs_in      = nbrs_ff;
      cand_in      = cand_ff;
      rest_in      = rest_ff;
      lb_in        = lb_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_dom_in   = rsp_dom_ff;
      rsp_nbr_in   = rsp_nbr_ff;
      rsp_nlb_in   = rsp_nlb_ff;
      rsp_last_in  = rsp_last_ff;
      adj_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               v_in = req_chan.node_index;
               if (req_chan.func == dvr_pkg::FuncWrite) begin
                  adj_req.wr_en   = 1'b1;
                  adj_req.wr_addr = req_chan.node_index;
                  adj_req.wr_data = req_chan.row_bits & ~req_bit;
                  lb_in = req_chan.in_lower_bound ? (lb_ff | req_bit) : (lb_ff & ~req_bit);
               end else begin
                  adj_req.rd_en   = 1'b1;
                  adj_req.rd_addr = req_chan.node_index;
                  state_in        = S_NBRS;
               end
            end
         end
         S_NBRS: begin
            nbrs_in  = rd_data;
            rest_in  = rd_data;
            cand_in  = ~rd_data & ~vbit;
            pend_in  = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // fold in the row read last cycle, issue the next neighbour
            if (pend_ff) begin
               cand_in = cand_ff & rd_data;
            end
            if (rest_ff != '0) begin
               adj_req.rd_en   = 1'b1;
               adj_req.rd_addr = rest_low;
               rest_in         = rest_next;
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (nbrs_ff == '0 || cand_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_dom_in   = '0;
                  rsp_nbr_in   = '0;
                  rsp_nlb_in   = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               u_in     = dvr_pkg::lowest_index(cand_ff);
               rest_in  = nbrs_ff;
               pend_in  = 1'b0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // write back the row read last cycle with bit v dropped
            if (pend_ff) begin
               adj_req.wr_en   = 1'b1;
               adj_req.wr_addr = wr_addr_ff;
               adj_req.wr_data = rd_data & ~vbit;
               pend_in         = 1'b0;
            end
            if (rest_ff != '0) begin
               if (slot_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b1;
                  rsp_dom_in      = u_ff;
                  rsp_nbr_in      = rest_low;
                  rsp_nlb_in      = lb_ff[rest_low];
                  rsp_last_in     = (rest_next == '0);
                  adj_req.rd_en   = 1'b1;
                  adj_req.rd_addr = rest_low;
                  wr_addr_in      = rest_low;
                  pend_in         = 1'b1;
                  rest_in         = rest_next;
               end
            end else if (!pend_ff) begin
               // drop v itself
               adj_req.wr_en   = 1'b1;
               adj_req.wr_addr = v_ff;
               adj_req.wr_data = '0;
               lb_in           = lb_ff & ~vbit;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         lb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         lb_ff        <= lb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      u_ff         <= u_in;
      wr_addr_ff   <= wr_addr_in;
      nbrs_ff      <= nbrs_in;
      cand_ff      <= cand_in;
      rest_ff      <= rest_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dom_ff   <= rsp_dom_in;
      rsp_nbr_ff   <= rsp_nbr_in;
      rsp_nlb_ff   <= rsp_nlb_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid                    = rsp_valid_ff;
   assign rsp_chan.found                    = rsp_found_ff;
   assign rsp_chan.dominating_node          = rsp_dom_ff;
   assign rsp_chan.neighbour                = rsp_nbr_ff;
   assign rsp_chan.neighbour_in_lower_bound = rsp_nlb_ff;
   assign rsp_chan.last                     = rsp_last_ff;

   // a read-modify-write never reads the row it is writing back
   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      (adj_req.rd_en && adj_req.wr_en) |-> (adj_req.rd_addr != adj_req.wr_addr))
      else $error("RAM read and write hit the same row");

   // no row read is left in flight when the block goes idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending row access while idle");

   // the neighbours still to visit stay within the neighbour set
   a_rest_in_nbrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_EMIT) |-> ((rest_ff & ~nbrs_ff) == '0))
      else $error("neighbour walk left the neighbour set");

   // a candidate is never a neighbour or the tested node
   a_cand_disjoint: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (((cand_ff & nbrs_ff) == '0) && ((cand_ff & vbit) == '0)))
      else $error("candidate set overlaps neighbours or tested node");

endmodule

[design/dvr_adj_ram.sv]
// Adjacency matrix RAM: one read and one write port, registered read data.
// Per-row valid bits make unwritten rows read as empty after reset.
// Depends on dvr_pkg.
module dvr_adj_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  dvr_pkg::adj_req_type  adj_req,
   output dvr_pkg::row_type      rd_data
);

   dvr_pkg::row_type                adj_mem [dvr_pkg::NodeCount];
   dvr_pkg::row_type                rd_row_ff;
   logic                            rd_valid_ff;
   logic [dvr_pkg::NodeCount-1:0]   row_valid_ff;

   always_ff @(posedge clock) begin
      if (adj_req.wr_en) begin
         adj_mem[adj_req.wr_addr] <= adj_req.wr_data;
      end
      if (adj_req.rd_en) begin
         rd_row_ff <= adj_mem[adj_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (adj_req.wr_en) begin
            row_valid_ff[adj_req.wr_addr] <= 1'b1;
         end
         if (adj_req.rd_en) begin
            rd_valid_ff <= row_valid_ff[adj_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_row_ff : '0;

endmodule

[dv/dvr_reduction_checker.sv]
// Checker for the dominated vertex reducer: mirrors the adjacency rows and lower-bound mask,
// predicts the response items of every request item and compares them in order.
// Depends on dvr_pkg and the channel interfaces in dvr_chan_if.
module dvr_reduction_checker (
   input  logic clock,
   input  logic reset,
   dvr_req_if   req_chan,
   dvr_rsp_if   rsp_chan,
   output int   error_count,
   output int   results_due,
   output int   results_seen,
   output int   removals_seen
);

   typedef struct packed {
      logic              found;
      dvr_pkg::node_type dominator;
      dvr_pkg::node_type neighbour;
      logic              neighbour_lb;
      logic              last;
   } reduce_result_type;

   dvr_pkg::row_type  graph_rows [dvr_pkg::NodeCount];
   dvr_pkg::row_type  lb_mask;
   reduce_result_type predicted_results [$];
   int                errors;
   int                seen;
   int                removals;

   function automatic void record_row_write(dvr_pkg::node_type n, dvr_pkg::row_type row,
                                            logic lb);
      graph_rows[n] = row & ~(dvr_pkg::row_type'(1) << n);
      lb_mask[n]    = lb;
   endfunction

   // intersect the rows of all neighbours, keep non-neighbours other than v, take the lowest
   function automatic void predict_reduction(dvr_pkg::node_type v);
      dvr_pkg::row_type  nbrs;
      dvr_pkg::row_type  cand;
      dvr_pkg::node_type dom;
      logic              hit;
      reduce_result_type r;
      nbrs = graph_rows[v];
      cand = ~nbrs & ~(dvr_pkg::row_type'(1) << v);
      for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
         if (nbrs[i]) begin
            cand &= graph_rows[i];
         end
      end
      if (nbrs == '0 || cand == '0) begin
         r = '{found: 1'b0, dominator: '0, neighbour: '0, neighbour_lb: 1'b0, last: 1'b1};
         predicted_results.push_back(r);
         return;
      end
      hit = 1'b0;
      dom = '0;
      for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
         if (!hit && cand[i]) begin
            dom = dvr_pkg::node_type'(i);
            hit = 1'b1;
         end
      end
      for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
         if (nbrs[i]) begin
            r.found        = 1'b1;
            r.dominator    = dom;
            r.neighbour    = dvr_pkg::node_type'(i);
            r.neighbour_lb = lb_mask[i];
            r.last         = ((nbrs >> (i + 1)) == '0);
            predicted_results.push_back(r);
         end
      end
      // drop v; asymmetric stale bits in non-neighbour rows stay
      for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
         if (nbrs[i]) begin
            graph_rows[i][v] = 1'b0;
         end
      end
      graph_rows[v] = '0;
      lb_mask[v]    = 1'b0;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   initial begin
      errors   = 0;
      seen     = 0;
      removals = 0;
   end

   always @(posedge clock) begin
      reduce_result_type want;
      if (reset) begin
         for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
            graph_rows[i] = '0;
         end
         lb_mask = '0;
         predicted_results.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_results.size() == 0) begin
               $error("response item with none expected: neighbour %0d", rsp_chan.neighbour);
               errors++;
            end else begin
               want = predicted_results.pop_front();
               check_field("found", want.found, rsp_chan.found);
               check_field("dominating_node", want.dominator, rsp_chan.dominating_node);
               check_field("neighbour", want.neighbour, rsp_chan.neighbour);
               check_field("neighbour_in_lower_bound", want.neighbour_lb,
                           rsp_chan.neighbour_in_lower_bound);
               check_field("last", want.last, rsp_chan.last);
               if (want.found && want.last) begin
                  removals++;
               end
            end
            seen++;
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.func == dvr_pkg::FuncWrite) begin
               record_row_write(req_chan.node_index, req_chan.row_bits, req_chan.in_lower_bound);
            end else begin
               predict_reduction(req_chan.node_index);
            end
         end
      end
      error_count   <= errors;
      results_due   <= predicted_results.size();
      results_seen  <= seen;
      removals_seen <= removals;
   end

endmodule

[dv/tb_dominated_vertex_reducer_core.sv]
// Testbench top for dominated_vertex_reducer_core: directed graph cases, then random graph
// episodes with forced dominations plus noise, random idling on both channels.
// Depends on dvr_pkg, dvr_chan_if and dvr_reduction_checker.
module tb_dominated_vertex_reducer_core;

   localparam int ItemTarget  = 480;
   localparam int CycleLimit  = 3000000;
   localparam int DrainCycles = 160;

   logic clock = 1'b0;
   logic reset;

   dvr_req_if req_chan ();
   dvr_rsp_if rsp_chan ();

   int error_count;
   int results_due;
   int results_seen;
   int removals_seen;
   int cycle_count = 0;
   int items_sent  = 0;
   int reduces_sent = 0;
   int rsp_seq     = 0;
   int episodes    = 0;

   dvr_pkg::row_type  graph_rows [dvr_pkg::NodeCount];
   dvr_pkg::node_type node_order [dvr_pkg::NodeCount];

   dominated_vertex_reducer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dvr_reduction_checker u_reduction_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .error_count   (error_count),
      .results_due   (results_due),
      .results_seen  (results_seen),
      .removals_seen (removals_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_dominated_vertex_reducer_core failed");
         $finish;
      end
   end

   // 40 items without idling in every 120
   function automatic int pick_wait(int seq);
      return ((seq / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic dvr_pkg::row_type random_row();
      return dvr_pkg::row_type'({$urandom, $urandom});
   endfunction

   // enter and leave at a falling edge
   task automatic push_request(logic f, dvr_pkg::node_type n, dvr_pkg::row_type row,
                               logic lb);
      int gap;
      gap = pick_wait(items_sent);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.func           <= f;
      req_chan.node_index     <= n;
      req_chan.row_bits       <= row;
      req_chan.in_lower_bound <= lb;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (f == dvr_pkg::FuncReduce) begin
         reduces_sent++;
      end
      @(negedge clock);
   endtask

   task automatic reduce_node(dvr_pkg::node_type n);
      push_request(dvr_pkg::FuncReduce, n, random_row(), 1'($urandom_range(0, 1)));
   endtask

   // build a graph on k random nodes, optionally make node_order[0] dominated by node_order[1]
   task automatic run_graph_episode(int k, int density, bit force_hit);
      dvr_pkg::node_type v;
      dvr_pkg::node_type u;
      dvr_pkg::node_type a;
      dvr_pkg::node_type b;
      int                j;
      for (int i = dvr_pkg::NodeCount - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         a = node_order[i];
         node_order[i] = node_order[j];
         node_order[j] = a;
      end
      for (int i = 0; i < k; i++) begin
         graph_rows[node_order[i]] = '0;
      end
      for (int i = 0; i < k; i++) begin
         for (int m = i + 1; m < k; m++) begin
            if ($urandom_range(0, 99) < density) begin
               graph_rows[node_order[i]][node_order[m]] = 1'b1;
               graph_rows[node_order[m]][node_order[i]] = 1'b1;
            end
         end
      end
      v = node_order[0];
      u = node_order[1];
      if (force_hit) begin
         graph_rows[u][v] = 1'b0;
         graph_rows[v][u] = 1'b0;
         for (int i = 2; i < k; i++) begin
            a = node_order[i];
            if (graph_rows[v][a]) begin
               graph_rows[u][a] = 1'b1;
               graph_rows[a][u] = 1'b1;
            end
         end
      end
      // occasional one-sided edge or self loop
      if ($urandom_range(0, 7) == 0) begin
         a = node_order[$urandom_range(0, k - 1)];
         b = dvr_pkg::node_type'($urandom_range(0, dvr_pkg::NodeCount - 1));
         graph_rows[a][b] = ~graph_rows[a][b];
      end
      for (int i = 0; i < k; i++) begin
         push_request(dvr_pkg::FuncWrite, node_order[i], graph_rows[node_order[i]],
                      1'($urandom_range(0, 1)));
      end
      reduce_node(v);
      repeat ($urandom_range(1, 4)) reduce_node(node_order[$urandom_range(0, k - 1)]);
      episodes++;
   endtask

   initial begin
      int rsp_gap;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         rsp_gap = pick_wait(rsp_seq);
         if (rsp_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         rsp_seq++;
         @(negedge clock);
      end
   end

   initial begin
      int pick;
      rsp_chan.ready          <= 1'b0;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.func           <= dvr_pkg::FuncWrite;
      req_chan.node_index     <= '0;
      req_chan.row_bits       <= '0;
      req_chan.in_lower_bound <= 1'b0;
      for (int i = 0; i < dvr_pkg::NodeCount; i++) begin
         node_order[i] = dvr_pkg::node_type'(i);
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed cases
      reduce_node(dvr_pkg::node_type'(5));                   // empty graph
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(63), '1, 1'b1); // own bit dropped
      reduce_node(dvr_pkg::node_type'(63));                  // adjacent to all, no candidate
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(1),
                   dvr_pkg::row_type'(64'h0e), 1'b1);        // self loop on node 1
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(2),
                   dvr_pkg::row_type'(64'h12), 1'b0);
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(3),
                   dvr_pkg::row_type'(64'h12), 1'b1);
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(4),
                   dvr_pkg::row_type'(64'h0c), 1'b1);
      reduce_node(dvr_pkg::node_type'(1));                   // dominated by node 4
      reduce_node(dvr_pkg::node_type'(1));                   // removed, degree zero
      reduce_node(dvr_pkg::node_type'(4));
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(10),
                   dvr_pkg::row_type'(64'h800), 1'b0);
      reduce_node(dvr_pkg::node_type'(10));                  // neighbour row still empty
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(11),
                   dvr_pkg::row_type'(64'h8000_0000_0000_1000), 1'b1);
      reduce_node(dvr_pkg::node_type'(10));                  // one-sided rows give a hit
      reduce_node(dvr_pkg::node_type'(11));
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(20),
                   dvr_pkg::row_type'(64'haaaa_aaaa_aaaa_aaaa), 1'b0);
      reduce_node(dvr_pkg::node_type'(20));
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(21),
                   dvr_pkg::row_type'(64'h5555_5555_5555_5555), 1'b1);
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(21), '0, 1'b0);
      push_request(dvr_pkg::FuncWrite, dvr_pkg::node_type'(0),
                   dvr_pkg::row_type'(64'h8000_0000_0000_0001), 1'b1);
      reduce_node(dvr_pkg::node_type'(0));                   // lowest of many dominators

      // random graph episodes, with noise and two full-size graphs
      while (items_sent < ItemTarget) begin
         pick = $urandom_range(0, 9);
         if (episodes == 4) begin
            run_graph_episode(dvr_pkg::NodeCount, 100, 1'b1);
         end else if (episodes == 20) begin
            run_graph_episode(dvr_pkg::NodeCount, 50, 1'b1);
         end else if (pick < 7) begin
            run_graph_episode($urandom_range(3, 10), $urandom_range(20, 80),
                              $urandom_range(0, 3) != 0);
         end else if (pick < 9) begin
            push_request(dvr_pkg::FuncWrite,
                         dvr_pkg::node_type'($urandom_range(0, dvr_pkg::NodeCount - 1)),
                         random_row() & random_row(), 1'($urandom_range(0, 1)));
         end else begin
            reduce_node(dvr_pkg::node_type'($urandom_range(0, dvr_pkg::NodeCount - 1)));
         end
      end
      req_chan.valid <= 1'b0;

      while (results_due != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("sent %0d items in %0d graph episodes, %0d of them reduce requests",
               items_sent, episodes, reduces_sent);
      $display("checked %0d response items, %0d nodes removed as dominated",
               results_seen, removals_seen);
      if (error_count == 0 && results_due == 0) begin
         $display("tb_dominated_vertex_reducer_core passed");
      end else begin
         $display("tb_dominated_vertex_reducer_core failed");
      end
      $finish;
   end

endmodule
